FILE: rtl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// No dependencies.
package ffba_pkg;

  localparam int unsigned DEF_HEAP_BLOCKS = 4096;
  localparam int unsigned DEF_MAX_EXTENTS = 2048;

  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned ADDR_W   = 13;
  localparam int unsigned STATUS_W = 2;

  localparam logic [ADDR_W-1:0] RESET_HEAP = 13'd4096;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_LIVE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_MEM   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_A_RD,
    S_A_CHK,
    S_F_MRD,
    S_F_MCHK,
    S_F_RD,
    S_F_CHK,
    S_F_DEC,
    S_DN_RD,
    S_DN_WR,
    S_UP_RD,
    S_UP_WR,
    S_INS_WR,
    S_FIN
  } state_e;

endpackage

FILE: rtl/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/first_fit_block_allocator_core.sv
// First-fit block allocator: sorted free-extent table and per-block
// allocation marks/sizes held in RAMs, walked by one sequencer.
// Allocate scans extents one at a time and, when an extent is used up, shifts
//   later entries down; free scans extents and shifts entries to merge or insert. One word at a time.
// Reset and every heap_blocks write start a clearing pass over every entry of
//   the mark RAM; input is stalled until it ends.
module first_fit_block_allocator_core #(
  parameter int unsigned HEAP_BLOCKS = ffba_pkg::DEF_HEAP_BLOCKS,
  parameter int unsigned MAX_EXTENTS = ffba_pkg::DEF_MAX_EXTENTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffba_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [ffba_pkg::SIZE_W-1:0]   size_blocks_i,
  input  logic [ffba_pkg::ADDR_W-1:0]   block_addr_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ffba_pkg::ADDR_W-1:0]   payload_addr_o,
  output logic [ffba_pkg::STATUS_W-1:0] status_o
);
  import ffba_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_BLOCKS);
  localparam int unsigned LW = $clog2(HEAP_BLOCKS + 1);
  localparam int unsigned CW = ((LW > ADDR_W) ? LW : ADDR_W) + 1;
  localparam int unsigned XW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned NW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned EW = AW + LW;

  state_e state_q, state_d;
  logic [NW-1:0] i_q, i_d, k_q, k_d, cnt_q, cnt_d;
  logic [ADDR_W-1:0] heap_q, heap_d;
  logic [AW-1:0] clr_q, clr_d, hdr_q, hdr_d;
  logic [CW-1:0] need_q, need_d;
  logic [AW-1:0] pst_q, pst_d, cst_q, cst_d;
  logic [LW-1:0] pln_q, pln_d, cln_q, cln_d, size_q, size_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic [STATUS_W-1:0] res_st_q, res_st_d;
  logic out_valid_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [STATUS_W-1:0] out_st_q;

  logic          ext_we;
  logic [XW-1:0] ext_waddr, ext_raddr;
  logic [EW-1:0] ext_wdata, ext_rdata;
  logic          mark_we, mark_wdata, mark_rdata;
  logic [AW-1:0] mark_waddr;
  logic          size_we;
  logic [LW-1:0] size_rdata;

  logic [AW-1:0] rstart;
  logic [LW-1:0] rlen, newlen, usable;
  logic [CW-1:0] heap_ext, hdr_n, addr_m1;
  logic [NW-1:0] k_p1, k_m1, i_m1;
  logic          to_next, to_prev, out_free;

  assign rstart   = ext_rdata[EW-1:LW];
  assign rlen     = ext_rdata[LW-1:0];
  assign newlen   = rlen - LW'(need_q);
  assign hdr_n    = CW'(rstart) + CW'(newlen);
  assign heap_ext = CW'(heap_q);
  assign usable   = (heap_ext > CW'(HEAP_BLOCKS)) ? LW'(HEAP_BLOCKS) : LW'(heap_q);
  assign addr_m1  = CW'(block_addr_i) - CW'(1);
  assign k_p1     = k_q + NW'(1);
  assign k_m1     = k_q - NW'(1);
  assign i_m1     = i_q - NW'(1);
  assign to_next  = (i_q < cnt_q) && ((CW'(hdr_q) + CW'(size_q)) == CW'(cst_q));
  assign to_prev  = (i_q != '0) && ((CW'(pst_q) + CW'(pln_q)) == CW'(hdr_q));
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign payload_addr_o = out_addr_q;
  assign status_o       = out_st_q;

  always_comb begin
    case (state_q)
      S_DN_RD: ext_raddr = k_p1[XW-1:0];
      S_UP_RD: ext_raddr = k_m1[XW-1:0];
      default: ext_raddr = i_q[XW-1:0];
    endcase
  end

  always_comb begin
    state_d = state_q;
    i_d = i_q; k_d = k_q; cnt_d = cnt_q; heap_d = heap_q; clr_d = clr_q;
    hdr_d = hdr_q; need_d = need_q; pst_d = pst_q; pln_d = pln_q;
    cst_d = cst_q; cln_d = cln_q; size_d = size_q;
    res_addr_d = res_addr_q; res_st_d = res_st_q;
    ext_we = 1'b0; ext_waddr = i_q[XW-1:0]; ext_wdata = {rstart, newlen};
    mark_we = 1'b0; mark_waddr = hdr_q; mark_wdata = 1'b0;
    size_we = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_addr_d = '0;
          i_d = '0;
          if (func_i == FUNC_ALLOC) begin
            need_d = CW'(size_blocks_i) + CW'(1);
            state_d = S_A_RD;
          end else if (block_addr_i == '0) begin
            res_st_d = ST_NULL;
            state_d = S_FIN;
          end else if (addr_m1 >= CW'(HEAP_BLOCKS)) begin
            res_st_d = ST_NOT_LIVE;
            state_d = S_FIN;
          end else begin
            hdr_d = AW'(addr_m1);
            state_d = S_F_MRD;
          end
        end
      end
      S_CLR: begin
        mark_we = 1'b1;
        mark_waddr = clr_q;
        if (clr_q == '0) begin
          ext_we = 1'b1;
          ext_waddr = '0;
          ext_wdata = {AW'(0), usable};
          cnt_d = (usable != '0) ? NW'(1) : NW'(0);
        end
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(HEAP_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_A_RD: begin
        if (i_q == cnt_q) begin
          res_st_d = ST_NO_MEM;
          state_d = S_FIN;
        end else begin
          state_d = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (CW'(rlen) >= need_q) begin
          mark_we = 1'b1;
          mark_waddr = AW'(hdr_n);
          mark_wdata = 1'b1;
          size_we = 1'b1;
          res_addr_d = ADDR_W'(hdr_n + CW'(1));
          res_st_d = ST_OK;
          if (newlen == '0) begin
            k_d = i_q;
            state_d = S_DN_RD;
          end else begin
            ext_we = 1'b1;
            state_d = S_FIN;
          end
        end else begin
          i_d = i_q + NW'(1);
          state_d = S_A_RD;
        end
      end
      S_F_MRD: state_d = S_F_MCHK;
      S_F_MCHK: begin
        size_d = size_rdata;
        if (!mark_rdata) begin
          res_st_d = ST_NOT_LIVE;
          state_d = S_FIN;
        end else begin
          state_d = S_F_RD;
        end
      end
      S_F_RD: state_d = (i_q == cnt_q) ? S_F_DEC : S_F_CHK;
      S_F_CHK: begin
        if (rstart < hdr_q) begin
          pst_d = rstart;
          pln_d = rlen;
          i_d = i_q + NW'(1);
          state_d = S_F_RD;
        end else begin
          cst_d = rstart;
          cln_d = rlen;
          state_d = S_F_DEC;
        end
      end
      S_F_DEC: begin
        res_st_d = ST_OK;
        state_d = S_FIN;
        if (to_prev) begin
          ext_we = 1'b1;
          ext_waddr = i_m1[XW-1:0];
          ext_wdata = to_next ? {pst_q, pln_q + size_q + cln_q} : {pst_q, pln_q + size_q};
          mark_we = 1'b1;
          if (to_next) begin
            k_d = i_q;
            state_d = S_DN_RD;
          end
        end else if (to_next) begin
          ext_we = 1'b1;
          ext_wdata = {hdr_q, cln_q + size_q};
          mark_we = 1'b1;
        end else if (cnt_q >= NW'(MAX_EXTENTS)) begin
          res_st_d = ST_NO_MEM;
        end else begin
          mark_we = 1'b1;
          k_d = cnt_q;
          state_d = S_UP_RD;
        end
      end
      // remove entry k: pull later entries down one slot
      S_DN_RD: begin
        if (k_p1 >= cnt_q) begin
          cnt_d = cnt_q - NW'(1);
          state_d = S_FIN;
        end else begin
          state_d = S_DN_WR;
        end
      end
      S_DN_WR: begin
        ext_we = 1'b1;
        ext_waddr = k_q[XW-1:0];
        ext_wdata = ext_rdata;
        k_d = k_p1;
        state_d = S_DN_RD;
      end
      // open a slot at i: push entries up one slot
      S_UP_RD: state_d = (k_q <= i_q) ? S_INS_WR : S_UP_WR;
      S_UP_WR: begin
        ext_we = 1'b1;
        ext_waddr = k_q[XW-1:0];
        ext_wdata = ext_rdata;
        k_d = k_m1;
        state_d = S_UP_RD;
      end
      S_INS_WR: begin
        ext_we = 1'b1;
        ext_wdata = {hdr_q, size_q};
        cnt_d = cnt_q + NW'(1);
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cfg_we_i) begin
      heap_d = cfg_wdata_i;
      clr_d = '0;
      state_d = S_CLR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      i_q <= '0; k_q <= '0; cnt_q <= '0;
      heap_q <= RESET_HEAP;
      clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q <= i_d; k_q <= k_d; cnt_q <= cnt_d;
      heap_q <= heap_d;
      clr_q <= clr_d;
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d; need_q <= need_d;
    pst_q <= pst_d; pln_q <= pln_d; cst_q <= cst_d; cln_q <= cln_d;
    size_q <= size_d;
    res_addr_q <= res_addr_d; res_st_q <= res_st_d;
    if (state_q == S_FIN && out_free) begin
      out_addr_q <= res_addr_q;
      out_st_q <= res_st_q;
    end
  end

  ffba_ram #(.WIDTH(EW), .DEPTH(MAX_EXTENTS), .AW(XW)) u_ext_ram (
    .clk_i, .we_i(ext_we), .waddr_i(ext_waddr), .wdata_i(ext_wdata),
    .raddr_i(ext_raddr), .rdata_o(ext_rdata)
  );

  ffba_ram #(.WIDTH(1), .DEPTH(HEAP_BLOCKS), .AW(AW)) u_mark_ram (
    .clk_i, .we_i(mark_we), .waddr_i(mark_waddr), .wdata_i(mark_wdata),
    .raddr_i(hdr_q), .rdata_o(mark_rdata)
  );

  ffba_ram #(.WIDTH(LW), .DEPTH(HEAP_BLOCKS), .AW(AW)) u_size_ram (
    .clk_i, .we_i(size_we), .waddr_i(AW'(hdr_n)), .wdata_i(LW'(need_q)),
    .raddr_i(hdr_q), .rdata_o(size_rdata)
  );

endmodule

FILE: rtl/ffba_checker.sv
// Port-level checks for first_fit_block_allocator_core, attached by bind.
// Depends on ffba_pkg.
module ffba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [ffba_pkg::ADDR_W-1:0]   payload_addr_o,
  input logic [ffba_pkg::STATUS_W-1:0] status_o
);
  import ffba_pkg::*;

  // a failed or rejected word never carries an address
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> payload_addr_o == '0)
    else $error("nonzero address with error status");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(payload_addr_o)
      && $stable(status_o)))
    else $error("stalled output word changed");

  // clearing pass follows reset and every heap size write
  a_rst_clear: assert property (@(posedge clk_i) !rst_ni |=> in_stall_o)
    else $error("input open during reset");

  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("input open after heap size write");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
  .clk_i, .rst_ni, .cfg_we_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .payload_addr_o, .status_o
);
